/* design/pds_pkg.sv */
// Package for the PLL divider search block: widths, constants, divider tables,
// controller/datapath command and status types, and the divider split function.
// No dependencies.
`timescale 1ns / 1ps

package pds_pkg;

  // Field and datapath widths
  localparam int PIX_W      = 29;  // pixel clock input
  localparam int LINK_W     = 32;  // 5 * pixel clock, never wraps
  localparam int DIV_W      = 7;   // overall divider
  localparam int DCO_W      = 39;  // divider * link clock
  localparam int CTR_W      = 34;  // DCO centre in Hz
  localparam int K_W        = 20;  // centre / 10000
  localparam int DEV_W      = 14;  // deviation, also limit register width
  localparam int THR_W      = DEV_W + K_W;
  localparam int X_W        = 29;  // qualified diff with K's power of two shifted out
  localparam int SH_W       = 4;   // that shift amount
  localparam int ODD_W      = 15;  // odd part of K
  localparam int RECIP_SH   = 32;  // reciprocal scale
  localparam int RECIP_W    = 22;  // floor(2^RECIP_SH / odd part)
  localparam int PROD_W     = X_W + RECIP_W;
  localparam int CSEL_W     = 2;
  localparam int IDX_W      = 6;   // index into the divider lists
  localparam int DCNT_W     = 1;   // divide step counter
  localparam int FIRST_W    = 3;
  localparam int MIDDLE_W   = 5;
  localparam int LAST_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DEV_W;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NEG = 2'd1;
  localparam logic [DEV_W-1:0]     MAX_POS_RST = 14'd100;
  localparam logic [DEV_W-1:0]     MAX_NEG_RST = 14'd600;

  // Search bounds
  localparam logic [CSEL_W-1:0] CSEL_LAST = 2'd2;
  localparam logic [IDX_W-1:0]  EVEN_LAST = 6'd35;
  localparam logic [IDX_W-1:0]  ODD_LAST  = 6'd6;
  localparam logic [DCNT_W-1:0] DCNT_LAST = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic              start;     // capture link clock, clear best
    logic              mul;       // dco = divider * link
    logic              diff;      // |dco - centre|
    logic              thr;       // threshold = min(limit, best) * K
    logic              div_init;  // load scaled diff
    logic              div_mul;   // quotient estimate by reciprocal
    logic              div_fix;   // correct estimate by one
    logic              commit;    // new best candidate
    logic              finish;    // load result register
    logic [DIV_W-1:0]  divider;
    logic [CSEL_W-1:0] csel;
  } pds_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic qualify;     // candidate inside limit and better than best
    logic zero_hit;    // deviation 0 at or above the centre
    logic best_valid;  // some candidate accepted so far
  } pds_sts_t;

  typedef struct packed {
    logic [FIRST_W-1:0]  first;
    logic [MIDDLE_W-1:0] middle;
    logic [LAST_W-1:0]   last;
  } factors_t;

  // DCO centre frequency in Hz
  function automatic logic [CTR_W-1:0] centre_hz(input logic [CSEL_W-1:0] c);
    case (c)
      2'd0:    centre_hz = 34'd8400000000;
      2'd1:    centre_hz = 34'd9000000000;
      2'd2:    centre_hz = 34'd9600000000;
      default: centre_hz = 34'd9600000000;
    endcase
  endfunction

  // Centre / 10000: deviation = floor(diff / K)
  function automatic logic [K_W-1:0] centre_k(input logic [CSEL_W-1:0] c);
    case (c)
      2'd0:    centre_k = 20'd840000;
      2'd1:    centre_k = 20'd900000;
      2'd2:    centre_k = 20'd960000;
      default: centre_k = 20'd960000;
    endcase
  endfunction

  // K = 2^shift * odd part
  function automatic logic [SH_W-1:0] centre_shift(input logic [CSEL_W-1:0] c);
    case (c)
      2'd0:    centre_shift = 4'd6;   // 840000 = 64 * 13125
      2'd1:    centre_shift = 4'd5;   // 900000 = 32 * 28125
      2'd2:    centre_shift = 4'd9;   // 960000 = 512 * 1875
      default: centre_shift = 4'd9;
    endcase
  endfunction

  function automatic logic [ODD_W-1:0] centre_odd(input logic [CSEL_W-1:0] c);
    case (c)
      2'd0:    centre_odd = 15'd13125;
      2'd1:    centre_odd = 15'd28125;
      2'd2:    centre_odd = 15'd1875;
      default: centre_odd = 15'd1875;
    endcase
  endfunction

  // floor(2^32 / odd part)
  function automatic logic [RECIP_W-1:0] centre_recip(input logic [CSEL_W-1:0] c);
    case (c)
      2'd0:    centre_recip = 22'd327235;
      2'd1:    centre_recip = 22'd152709;
      2'd2:    centre_recip = 22'd2290649;
      default: centre_recip = 22'd2290649;
    endcase
  endfunction

  // Candidate dividers: even list when group is 0, odd list when 1
  function automatic logic [DIV_W-1:0] list_div(input logic group,
                                                input logic [IDX_W-1:0] idx);
    logic [DIV_W-1:0] d;
    d = '0;
    if (group) begin
      case (idx)
        6'd0: d = 7'd3;   6'd1: d = 7'd5;   6'd2: d = 7'd7;   6'd3: d = 7'd9;
        6'd4: d = 7'd15;  6'd5: d = 7'd21;  6'd6: d = 7'd35;
        default: d = '0;
      endcase
    end else begin
      case (idx)
        6'd0:  d = 7'd4;   6'd1:  d = 7'd6;   6'd2:  d = 7'd8;   6'd3:  d = 7'd10;
        6'd4:  d = 7'd12;  6'd5:  d = 7'd14;  6'd6:  d = 7'd16;  6'd7:  d = 7'd18;
        6'd8:  d = 7'd20;  6'd9:  d = 7'd24;  6'd10: d = 7'd28;  6'd11: d = 7'd30;
        6'd12: d = 7'd32;  6'd13: d = 7'd36;  6'd14: d = 7'd40;  6'd15: d = 7'd42;
        6'd16: d = 7'd44;  6'd17: d = 7'd48;  6'd18: d = 7'd52;  6'd19: d = 7'd54;
        6'd20: d = 7'd56;  6'd21: d = 7'd60;  6'd22: d = 7'd64;  6'd23: d = 7'd66;
        6'd24: d = 7'd68;  6'd25: d = 7'd70;  6'd26: d = 7'd72;  6'd27: d = 7'd76;
        6'd28: d = 7'd78;  6'd29: d = 7'd80;  6'd30: d = 7'd84;  6'd31: d = 7'd88;
        6'd32: d = 7'd90;  6'd33: d = 7'd92;  6'd34: d = 7'd96;  6'd35: d = 7'd98;
        default: d = '0;
      endcase
    end
    return d;
  endfunction

  // Split a divider into first * middle * last; zero off the lists unless p % 4 == 0
  function automatic factors_t split_div(input logic [DIV_W-1:0] p);
    factors_t f;
    f = '0;
    if (p[1:0] == 2'b00 && p != '0) begin
      // multiple of four: 2 * (p/4) * 2
      f = '{3'd2, p[DIV_W-1:2], 3'd2};
    end else begin
      case (p)
        7'd6:    f = '{3'd2, 5'd1,  3'd3};
        7'd10:   f = '{3'd2, 5'd1,  3'd5};
        7'd14:   f = '{3'd7, 5'd1,  3'd2};
        7'd18:   f = '{3'd3, 5'd3,  3'd2};
        7'd30:   f = '{3'd3, 5'd5,  3'd2};
        7'd42:   f = '{3'd3, 5'd7,  3'd2};
        7'd54:   f = '{3'd3, 5'd9,  3'd2};
        7'd66:   f = '{3'd3, 5'd11, 3'd2};
        7'd70:   f = '{3'd7, 5'd5,  3'd2};
        7'd78:   f = '{3'd3, 5'd13, 3'd2};
        7'd90:   f = '{3'd3, 5'd15, 3'd2};
        7'd98:   f = '{3'd7, 5'd7,  3'd2};
        7'd3:    f = '{3'd3, 5'd1,  3'd1};
        7'd5:    f = '{3'd5, 5'd1,  3'd1};
        7'd7:    f = '{3'd7, 5'd1,  3'd1};
        7'd9:    f = '{3'd3, 5'd1,  3'd3};
        7'd15:   f = '{3'd3, 5'd1,  3'd5};
        7'd21:   f = '{3'd7, 5'd1,  3'd3};
        7'd35:   f = '{3'd7, 5'd1,  3'd5};
        default: f = '0;
      endcase
    end
    return f;
  endfunction

endpackage

/* design/pds_channels.sv */
// Valid/ready channel interfaces for the PLL divider search block.
// Depends on pds_pkg.
`timescale 1ns / 1ps

interface pds_in_if;
  import pds_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_clock_hz;

  modport source (output valid, output pixel_clock_hz, input ready);
  modport sink   (input valid, input pixel_clock_hz, output ready);
endinterface

interface pds_out_if;
  import pds_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [CSEL_W-1:0]   centre_select;
  logic [DIV_W-1:0]    total_divider;
  logic [FIRST_W-1:0]  first_factor;
  logic [MIDDLE_W-1:0] middle_factor;
  logic [LAST_W-1:0]   last_factor;

  modport source (output valid, output found, output centre_select, output total_divider,
                  output first_factor, output middle_factor, output last_factor,
                  input ready);
  modport sink   (input valid, input found, input centre_select, input total_divider,
                  input first_factor, input middle_factor, input last_factor,
                  output ready);
endinterface

/* design/pds_datapath.sv */
// Datapath of the PLL divider search: limit registers, candidate arithmetic,
// reciprocal-multiply deviation divide, best-candidate tracking and result register.
// Depends on pds_pkg.
`timescale 1ns / 1ps

module pds_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pds_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [pds_pkg::PIX_W-1:0]      pixel_clock_hz,
  input  pds_pkg::pds_cmd_t              cmd,
  output pds_pkg::pds_sts_t              sts,
  output logic                           res_found,
  output logic [pds_pkg::CSEL_W-1:0]     res_csel,
  output logic [pds_pkg::DIV_W-1:0]      res_divider,
  output pds_pkg::factors_t              res_factors
);
  import pds_pkg::*;

  logic [DEV_W-1:0]  max_pos_r, max_neg_r;
  logic [LINK_W-1:0] link_r;
  logic [DCO_W-1:0]  dco_r, diff_r;
  logic              above_r;
  logic [THR_W-1:0]  thr_r;
  logic [X_W-1:0]    x_r;
  logic [DEV_W-1:0]  q0_r, quot_r, best_dev_r;
  logic [DIV_W-1:0]  best_p_r;
  logic [CSEL_W-1:0] best_c_r;
  logic              best_valid_r;

  logic [CTR_W-1:0]   ctr;
  logic [K_W-1:0]     k;
  logic [DEV_W-1:0]   limit, eff;
  logic [ODD_W-1:0]   d_odd;
  logic [RECIP_W-1:0] recip;
  logic [DCO_W-1:0]   diff_sh;
  logic [PROD_W-1:0]  prod;
  logic [X_W-1:0]     rem;

  // Centre constants for the candidate in flight
  assign ctr   = centre_hz(cmd.csel);
  assign k     = centre_k(cmd.csel);
  assign d_odd = centre_odd(cmd.csel);
  assign recip = centre_recip(cmd.csel);

  // Effective bound: limit of the side, tightened by the best so far
  always_comb begin
    limit = above_r ? max_pos_r : max_neg_r;
    eff   = (best_valid_r && best_dev_r < limit) ? best_dev_r : limit;
  end

  // dev < eff  <=>  diff < eff * K
  assign sts.qualify    = diff_r < DCO_W'(thr_r);
  assign sts.zero_hit   = above_r && (diff_r < DCO_W'(k));
  assign sts.best_valid = best_valid_r;

  // Divide helpers: a qualified diff shifted by K's power of two fits X_W;
  // the reciprocal estimate is low by at most one
  assign diff_sh = diff_r >> centre_shift(cmd.csel);
  assign prod    = PROD_W'(x_r) * PROD_W'(recip);
  assign rem     = x_r - X_W'(q0_r) * X_W'(d_odd);

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pos_r <= MAX_POS_RST;
      max_neg_r <= MAX_NEG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_POS: max_pos_r <= cfg_wdata;
        REG_MAX_NEG: max_neg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Best-candidate flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (cmd.start) begin
      best_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      best_valid_r <= 1'b1;
    end
  end

  // Candidate arithmetic and division
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      link_r   <= LINK_W'({pixel_clock_hz, 2'b00}) + LINK_W'(pixel_clock_hz);
      best_p_r <= '0;
      best_c_r <= '0;
    end
    if (cmd.mul) begin
      dco_r <= DCO_W'(cmd.divider) * DCO_W'(link_r);
    end
    if (cmd.diff) begin
      above_r <= dco_r >= DCO_W'(ctr);
      diff_r  <= (dco_r >= DCO_W'(ctr)) ? dco_r - DCO_W'(ctr) : DCO_W'(ctr) - dco_r;
    end
    if (cmd.thr) begin
      thr_r <= THR_W'(eff) * THR_W'(k);
    end
    // floor(diff / K): shift, multiply by reciprocal of the odd part, fix by one
    if (cmd.div_init) begin
      x_r <= diff_sh[X_W-1:0];
    end
    if (cmd.div_mul) begin
      q0_r <= prod[RECIP_SH +: DEV_W];
    end
    if (cmd.div_fix) begin
      quot_r <= q0_r + DEV_W'(rem >= X_W'(d_odd));
    end
    if (cmd.commit) begin
      best_dev_r <= quot_r;
      best_p_r   <= cmd.divider;
      best_c_r   <= cmd.csel;
    end
    // Result register; best divider and centre are zero when nothing qualified
    if (cmd.finish) begin
      res_found   <= best_valid_r;
      res_csel    <= best_c_r;
      res_divider <= best_p_r;
      res_factors <= split_div(best_p_r);
    end
  end

endmodule

/* design/pds_ctrl.sv */
// Controller of the PLL divider search: walks groups, centres and dividers,
// sequences the datapath and owns the input/output handshakes.
// Depends on pds_pkg.
`timescale 1ns / 1ps

module pds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pds_pkg::pds_sts_t sts,
  output pds_pkg::pds_cmd_t cmd
);
  import pds_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DIFF   = 3'd2;
  localparam logic [2:0] S_THR    = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic              group_r, group_nxt;
  logic [CSEL_W-1:0] csel_r, csel_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              stop_r, stop_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]  last_idx;
  logic              adv, adv_stop, adv_found;

  assign last_idx  = group_r ? ODD_LAST : EVEN_LAST;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencing
  always_comb begin
    state_nxt     = state_r;
    group_nxt     = group_r;
    csel_nxt      = csel_r;
    idx_nxt       = idx_r;
    stop_nxt      = stop_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    adv           = 1'b0;
    adv_stop      = 1'b0;
    adv_found     = sts.best_valid;
    cmd           = '0;
    cmd.divider   = list_div(group_r, idx_r);
    cmd.csel      = csel_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          group_nxt = 1'b0;
          csel_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_THR;
      end
      S_THR: begin
        cmd.thr   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.qualify) begin
          cmd.div_init = 1'b1;
          dcnt_nxt     = '0;
          stop_nxt     = sts.zero_hit;
          state_nxt    = S_DIV;
        end else begin
          adv      = 1'b1;
          adv_stop = sts.zero_hit;
        end
      end
      S_DIV: begin
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_LAST) begin
          cmd.div_fix = 1'b1;
          state_nxt   = S_COMMIT;
        end else begin
          cmd.div_mul = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        adv        = 1'b1;
        adv_stop   = stop_r;
        adv_found  = 1'b1;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Next candidate: divider, then centre, then odd group if nothing found
    if (adv) begin
      if (!adv_stop && idx_r != last_idx) begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_MUL;
      end else if (!adv_stop && csel_r != CSEL_LAST) begin
        csel_nxt  = csel_r + 1'b1;
        idx_nxt   = '0;
        state_nxt = S_MUL;
      end else if (!group_r && !adv_found) begin
        group_nxt = 1'b1;
        csel_nxt  = '0;
        idx_nxt   = '0;
        state_nxt = S_MUL;
      end else begin
        state_nxt = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      group_r     <= 1'b0;
      csel_r      <= '0;
      idx_r       <= '0;
      stop_r      <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      group_r     <= group_nxt;
      csel_r      <= csel_nxt;
      idx_r       <= idx_nxt;
      stop_r      <= stop_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_MUL))
    else $error("accepted transaction did not start the search");

  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (idx_r <= last_idx))
    else $error("divider index past end of list");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result presented outside finish step");

  a_commit_sets_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |=> sts.best_valid)
    else $error("commit did not record a best candidate");

  a_odd_only_without_best: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(group_r) |-> !sts.best_valid)
    else $error("odd dividers searched after an even solution");
`endif

endmodule

/* design/pll_divider_search.sv */
// Top level of the PLL divider search: controller plus datapath behind
// valid/ready channels. Depends on pds_pkg, pds_channels, pds_ctrl, pds_datapath.
//
// One request at a time: the link clock (5 x pixel clock) is tried against each
// even divider and each of the three DCO centres, then the odd dividers if no
// even one qualified. Each candidate passes the multiply, subtract, threshold and
// compare steps of the single shared path, and a candidate that improves the best
// adds the reciprocal-multiply deviation divide (estimate, then fix by one) and a
// step to record it. A request holds up to 129 candidates between its idle accept
// step and its finish step; an exact hit on the positive side cuts its group
// short. A new request is taken while the previous result still waits in the
// output register; the finish step waits until that register is free.
`timescale 1ns / 1ps

module pll_divider_search (
  input  logic                           clk,
  input  logic                           rst_n,
  pds_in_if.sink                         in_ch,
  pds_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pds_pkg::*;

  pds_cmd_t cmd;
  pds_sts_t sts;
  factors_t res_factors;

  // Sequencer
  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result register
  pds_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pixel_clock_hz (in_ch.pixel_clock_hz),
    .cmd            (cmd),
    .sts            (sts),
    .res_found      (out_ch.found),
    .res_csel       (out_ch.centre_select),
    .res_divider    (out_ch.total_divider),
    .res_factors    (res_factors)
  );

  assign out_ch.first_factor  = res_factors.first;
  assign out_ch.middle_factor = res_factors.middle;
  assign out_ch.last_factor   = res_factors.last;

endmodule
